/* rtl/rci_pkg.sv */
package rci_pkg;

   // field widths
   localparam int LEN_W  = 32;
   localparam int COS_W  = 32;
   localparam int TOL_W  = 31;
   localparam int CNT_W  = 2;

   // internal widths of the quadratic
   localparam int AMAG_W = 31;
   localparam int BMAG_W = 63;
   localparam int CMAG_W = 64;
   localparam int DISC_W = 128;
   localparam int ROOT_W = DISC_W / 2;
   localparam int FRAC_W = 30;

   // distances saturate at 2^CAP_EXP inside the dividers
   localparam int CAP_EXP = 62;
   localparam int DIST_W  = CAP_EXP + 1;

   // cosine of one in Q2.30
   localparam logic signed [COS_W-1:0] COS_ONE = 32'sd1073741824;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONE_COS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_TOL = 2'd1;
   localparam logic [COS_W-1:0] CONE_COS_RESET = 32'd759250125;
   localparam logic [TOL_W-1:0] ZERO_TOL_RESET = 31'd1;

   // coefficients of one ray, carried alongside the square root
   typedef struct packed {
      logic                     linear;
      logic                     live_lin;
      logic                     disc_ok;
      logic [BMAG_W-1:0]        bmag;
      logic                     bneg;
      logic [AMAG_W-1:0]        amag;
      logic                     aneg;
      logic [CMAG_W-1:0]        cmag;
      logic                     cneg;
      logic signed [LEN_W-1:0]  z;
      logic signed [COS_W-1:0]  dz;
   } root_tag_type;

   // what the nappe check needs, carried alongside the dividers
   typedef struct packed {
      logic                     cand_a;
      logic signed [LEN_W-1:0]  z;
      logic signed [COS_W-1:0]  dz;
   } hit_tag_type;

   // limit a cosine to plus or minus one
   function automatic logic signed [COS_W-1:0] clamp_cos(input logic signed [COS_W-1:0] v);
      logic signed [COS_W-1:0] r;
      if (v > COS_ONE) begin
         r = COS_ONE;
      end else if (v < -COS_ONE) begin
         r = -COS_ONE;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

/* rtl/rci_setup.sv */
module rci_setup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic [rci_pkg::LEN_W-1:0]           in_radius,
   input  logic signed [rci_pkg::LEN_W-1:0]    in_z,
   input  logic signed [rci_pkg::COS_W-1:0]    in_dir_z,
   input  logic signed [rci_pkg::COS_W-1:0]    in_ray_cos,
   input  logic signed [rci_pkg::COS_W-1:0]    cone_cos,
   input  logic [rci_pkg::TOL_W-1:0]           zero_tol,
   output logic                                out_valid,
   output logic [rci_pkg::DISC_W-1:0]          out_disc,
   output rci_pkg::root_tag_type               out_tag
);

   // stage 1: clamp and first products
   logic signed [31:0] dz_c, rc_c, cc_c;
   logic signed [63:0] cc_sq, dz_sq, zdz_w, zz_w;
   logic [31:0]        rc_abs;
   logic [62:0]        rrc_w;
   logic [63:0]        rr_w;

   logic               s1_vld_ff;
   logic [30:0]        s1_c2_ff, s1_d2_ff;
   logic signed [63:0] s1_zdz_ff;
   logic [62:0]        s1_z2_ff;
   logic [62:0]        s1_rrc_ff;
   logic [63:0]        s1_rr_ff;
   logic               s1_rnz_ff, s1_rcneg_ff;
   logic signed [31:0] s1_z_ff, s1_dz_ff;

   assign dz_c   = rci_pkg::clamp_cos(in_dir_z);
   assign rc_c   = rci_pkg::clamp_cos(in_ray_cos);
   assign cc_c   = rci_pkg::clamp_cos(cone_cos);
   assign cc_sq  = cc_c * cc_c;
   assign dz_sq  = dz_c * dz_c;
   assign zdz_w  = in_z * dz_c;
   assign zz_w   = in_z * in_z;
   assign rc_abs = rc_c[31] ? 32'(-rc_c) : 32'(rc_c);
   assign rrc_w  = in_radius * rc_abs[30:0];
   assign rr_w   = in_radius * in_radius;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_c2_ff    <= cc_sq[60:30];
         s1_d2_ff    <= dz_sq[60:30];
         s1_zdz_ff   <= zdz_w;
         s1_z2_ff    <= zz_w[62:0];
         s1_rrc_ff   <= rrc_w;
         s1_rr_ff    <= rr_w;
         s1_rnz_ff   <= in_radius != '0;
         s1_rcneg_ff <= rc_c[31];
         s1_z_ff     <= in_z;
         s1_dz_ff    <= dz_c;
      end
   end

   // stage 2: a, and partial products of the c2 scaling
   logic signed [31:0] a_w;
   logic [62:0]        tlo_w, ulo_w, uhi_w;
   logic [61:0]        thi_w;

   logic               s2_vld_ff;
   logic signed [31:0] s2_a_ff;
   logic [62:0]        s2_tlo_ff, s2_ulo_ff, s2_uhi_ff;
   logic [61:0]        s2_thi_ff;
   logic signed [63:0] s2_zdz_ff;
   logic [62:0]        s2_z2_ff;
   logic               s2_rnz_ff, s2_rcneg_ff;
   logic signed [31:0] s2_z_ff, s2_dz_ff;

   assign a_w   = $signed({1'b0, s1_d2_ff}) - $signed({1'b0, s1_c2_ff});
   assign tlo_w = s1_rrc_ff[31:0] * s1_c2_ff;
   assign thi_w = s1_rrc_ff[62:32] * s1_c2_ff;
   assign ulo_w = s1_rr_ff[31:0] * s1_c2_ff;
   assign uhi_w = s1_rr_ff[63:32] * s1_c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (enable) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_a_ff     <= a_w;
         s2_tlo_ff   <= tlo_w;
         s2_thi_ff   <= thi_w;
         s2_ulo_ff   <= ulo_w;
         s2_uhi_ff   <= uhi_w;
         s2_zdz_ff   <= s1_zdz_ff;
         s2_z2_ff    <= s1_z2_ff;
         s2_rnz_ff   <= s1_rnz_ff;
         s2_rcneg_ff <= s1_rcneg_ff;
         s2_z_ff     <= s1_z_ff;
         s2_dz_ff    <= s1_dz_ff;
      end
   end

   // stage 3: combine partials, magnitude of a, linear test
   logic [95:0] t_full, u_full;
   logic [31:0] a_abs;
   logic        lin_w;

   logic               s3_vld_ff;
   logic [62:0]        s3_tmag_ff;
   logic [63:0]        s3_u_ff;
   logic [30:0]        s3_amag_ff;
   logic               s3_aneg_ff, s3_lin_ff;
   logic signed [63:0] s3_zdz_ff;
   logic [62:0]        s3_z2_ff;
   logic               s3_rnz_ff, s3_rcneg_ff;
   logic signed [31:0] s3_z_ff, s3_dz_ff;

   assign t_full = (96'(s2_thi_ff) << 32) + 96'(s2_tlo_ff);
   assign u_full = (96'(s2_uhi_ff) << 32) + 96'(s2_ulo_ff);
   assign a_abs  = s2_a_ff[31] ? 32'(-s2_a_ff) : 32'(s2_a_ff);
   assign lin_w  = a_abs[30:0] <= zero_tol;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (enable) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_tmag_ff  <= t_full[92:30];
         s3_u_ff     <= u_full[93:30];
         s3_amag_ff  <= a_abs[30:0];
         s3_aneg_ff  <= s2_a_ff[31];
         s3_lin_ff   <= lin_w;
         s3_zdz_ff   <= s2_zdz_ff;
         s3_z2_ff    <= s2_z2_ff;
         s3_rnz_ff   <= s2_rnz_ff;
         s3_rcneg_ff <= s2_rcneg_ff;
         s3_z_ff     <= s2_z_ff;
         s3_dz_ff    <= s2_dz_ff;
      end
   end

   // stage 4: b and c as sign and magnitude
   logic signed [63:0] t_s, b_w;
   logic [63:0]        b_abs;
   logic               cneg_w;
   logic [63:0]        cmag_w;
   rci_pkg::root_tag_type s4_tag_in;

   logic                  s4_vld_ff, s4_rnz_ff;
   rci_pkg::root_tag_type s4_tag_ff;

   always_comb begin
      t_s    = s3_rcneg_ff ? -$signed({1'b0, s3_tmag_ff}) : $signed({1'b0, s3_tmag_ff});
      b_w    = s3_zdz_ff - t_s;
      b_abs  = b_w[63] ? 64'(-b_w) : 64'(b_w);
      cneg_w = {1'b0, s3_z2_ff} < s3_u_ff;
      cmag_w = cneg_w ? s3_u_ff - {1'b0, s3_z2_ff} : {1'b0, s3_z2_ff} - s3_u_ff;
      s4_tag_in          = '0;
      s4_tag_in.linear   = s3_lin_ff;
      s4_tag_in.bmag     = b_abs[62:0];
      s4_tag_in.bneg     = b_w[63];
      s4_tag_in.amag     = s3_amag_ff;
      s4_tag_in.aneg     = s3_aneg_ff;
      s4_tag_in.cmag     = cmag_w;
      s4_tag_in.cneg     = cneg_w;
      s4_tag_in.z        = s3_z_ff;
      s4_tag_in.dz       = s3_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (enable) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s4_tag_ff <= s4_tag_in;
         s4_rnz_ff <= s3_rnz_ff;
      end
   end

   // stage 5: partial products of b^2 and a*c
   logic [63:0] ll_w;
   logic [62:0] lh_w, acl_w, ach_w;
   logic [61:0] hh_w;

   logic                  s5_vld_ff, s5_rnz_ff;
   rci_pkg::root_tag_type s5_tag_ff;
   logic [63:0]           s5_ll_ff;
   logic [62:0]           s5_lh_ff, s5_acl_ff, s5_ach_ff;
   logic [61:0]           s5_hh_ff;

   assign ll_w  = s4_tag_ff.bmag[31:0] * s4_tag_ff.bmag[31:0];
   assign lh_w  = s4_tag_ff.bmag[31:0] * s4_tag_ff.bmag[62:32];
   assign hh_w  = s4_tag_ff.bmag[62:32] * s4_tag_ff.bmag[62:32];
   assign acl_w = s4_tag_ff.amag * s4_tag_ff.cmag[31:0];
   assign ach_w = s4_tag_ff.amag * s4_tag_ff.cmag[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (enable) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s5_tag_ff <= s4_tag_ff;
         s5_rnz_ff <= s4_rnz_ff;
         s5_ll_ff  <= ll_w;
         s5_lh_ff  <= lh_w;
         s5_hh_ff  <= hh_w;
         s5_acl_ff <= acl_w;
         s5_ach_ff <= ach_w;
      end
   end

   // stage 6: assemble b^2 and a*c scaled to the same point
   logic [127:0] b2_w, ac_w;
   logic         acneg_w;

   logic                  s6_vld_ff, s6_rnz_ff, s6_acneg_ff;
   rci_pkg::root_tag_type s6_tag_ff;
   logic [127:0]          s6_b2_ff, s6_ac_ff;

   assign b2_w    = (128'(s5_hh_ff) << 64) + (128'(s5_lh_ff) << 33) + 128'(s5_ll_ff);
   assign ac_w    = ((128'(s5_ach_ff) << 32) + 128'(s5_acl_ff)) << rci_pkg::FRAC_W;
   assign acneg_w = (s5_tag_ff.cmag != '0) && (s5_tag_ff.aneg != s5_tag_ff.cneg);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (enable) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s6_tag_ff   <= s5_tag_ff;
         s6_rnz_ff   <= s5_rnz_ff;
         s6_acneg_ff <= acneg_w;
         s6_b2_ff    <= b2_w;
         s6_ac_ff    <= ac_w;
      end
   end

   // stage 7: discriminant and root conditions
   logic                  gt_w;
   logic [127:0]          disc_in;
   rci_pkg::root_tag_type tag_in;

   logic                  s7_vld_ff;
   logic [127:0]          s7_disc_ff;
   rci_pkg::root_tag_type s7_tag_ff;

   always_comb begin
      gt_w = s6_b2_ff > s6_ac_ff;
      if (s6_acneg_ff) begin
         disc_in = s6_b2_ff + s6_ac_ff;
      end else if (gt_w) begin
         disc_in = s6_b2_ff - s6_ac_ff;
      end else begin
         disc_in = '0;
      end
      tag_in          = s6_tag_ff;
      tag_in.disc_ok  = s6_rnz_ff && (s6_acneg_ff || gt_w);
      tag_in.live_lin = s6_rnz_ff && (s6_tag_ff.bmag != '0) && (s6_tag_ff.cmag != '0)
                        && (s6_tag_ff.cneg != s6_tag_ff.bneg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (enable) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s7_disc_ff <= disc_in;
         s7_tag_ff  <= tag_in;
      end
   end

   assign out_valid = s7_vld_ff;
   assign out_disc  = s7_disc_ff;
   assign out_tag   = s7_tag_ff;

endmodule

/* rtl/rci_sqrt.sv */
module rci_sqrt #(
   parameter int RAD_W = rci_pkg::DISC_W,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic              vld_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];

   // one root bit per stage, restoring digit recurrence
   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic              vld_prev;
      logic [REM_W-1:0]  rem_prev, rem2, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [RAD_W-1:0]  rad_prev;
      logic [TAG_W-1:0]  tag_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      always_comb begin
         rem2  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial = {root_prev, 2'b01};
         if (rem2 >= trial) begin
            rem_in  = rem2 - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_prev << 2;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

/* rtl/rci_div.sv */
module rci_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 31,
   parameter int QUO_W = rci_pkg::CAP_EXP,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [NUM_W-1:0]     in_num,
   input  logic [DEN_W-1:0]     in_den,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [QUO_W:0]       out_quo,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   // entry stage: saturation test, remainder seeded with the high part
   logic [CMP_W-1:0] hi_ext, den_ext;

   logic             pre_vld_ff, pre_sat_ff;
   logic [DEN_W-1:0] pre_rem_ff, pre_den_ff;
   logic [QUO_W-1:0] pre_low_ff;
   logic [TAG_W-1:0] pre_tag_ff;

   assign hi_ext  = CMP_W'(in_num[NUM_W-1:QUO_W]);
   assign den_ext = CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (enable) begin
         pre_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pre_sat_ff <= hi_ext >= den_ext;
         pre_rem_ff <= hi_ext[DEN_W-1:0];
         pre_den_ff <= in_den;
         pre_low_ff <= in_num[QUO_W-1:0];
         pre_tag_ff <= in_tag;
      end
   end

   logic             vld_ff [QUO_W];
   logic             sat_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];

   // one quotient bit per stage
   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic             vld_prev, sat_prev, ge;
      logic [DEN_W-1:0] rem_prev, den_prev, rem_in;
      logic [DEN_W:0]   rem2, diff;
      logic [QUO_W-1:0] low_prev, quo_prev;
      logic [TAG_W-1:0] tag_prev;

      if (k == 0) begin : g_first
         assign vld_prev = pre_vld_ff;
         assign sat_prev = pre_sat_ff;
         assign rem_prev = pre_rem_ff;
         assign den_prev = pre_den_ff;
         assign low_prev = pre_low_ff;
         assign quo_prev = '0;
         assign tag_prev = pre_tag_ff;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign sat_prev = sat_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      always_comb begin
         rem2   = {rem_prev, low_prev[QUO_W-1]};
         diff   = rem2 - {1'b0, den_prev};
         ge     = rem2 >= {1'b0, den_prev};
         rem_in = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sat_ff[k] <= sat_prev;
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            low_ff[k] <= low_prev << 1;
            quo_ff[k] <= {quo_prev[QUO_W-2:0], ge};
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = sat_ff[QUO_W-1] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo_ff[QUO_W-1]};
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

/* rtl/ray_cone_intersect.sv */
// Ray against a double cone about the z axis: one request per clock unless stalled (7 stages set
// up A, B, C and the discriminant, 64 stages take the square root one bit each, 1 stage forms q,
// 63 stages run the two distance divisions, a saturation test then one quotient bit each, 2 stages
// test the nappe). The whole pipeline freezes while a result waits under rsp_stall; req_stall is
// high exactly then. cone_cos and zero_tolerance are read live, so write them only while no
// request is in flight. Distances are Q20.12 and saturate at all ones.
module ray_cone_intersect (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rci_pkg::LEN_W-1:0]             req_origin_radius,
   input  logic signed [rci_pkg::LEN_W-1:0]      req_origin_z,
   input  logic signed [rci_pkg::COS_W-1:0]      req_dir_z,
   input  logic signed [rci_pkg::COS_W-1:0]      req_ray_cos,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rci_pkg::CNT_W-1:0]             rsp_hit_count,
   output logic [rci_pkg::LEN_W-1:0]             rsp_first_distance,
   output logic [rci_pkg::LEN_W-1:0]             rsp_second_distance,
   input  logic                                  csr_write,
   input  logic [rci_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rci_pkg::COS_W-1:0]             csr_data
);

   localparam int HIT_TAG_W  = $bits(rci_pkg::hit_tag_type);
   localparam int ROOT_TAG_W = $bits(rci_pkg::root_tag_type);

   logic enable;
   logic rsp_valid_ff;

   // whole pipeline advances unless a result is held
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // configuration registers
   logic signed [rci_pkg::COS_W-1:0] cone_cos_ff;
   logic [rci_pkg::TOL_W-1:0]        zero_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cone_cos_ff <= rci_pkg::CONE_COS_RESET;
         zero_tol_ff <= rci_pkg::ZERO_TOL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rci_pkg::CSR_CONE_COS: cone_cos_ff <= csr_data;
            rci_pkg::CSR_ZERO_TOL: zero_tol_ff <= csr_data[rci_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // coefficients and discriminant
   logic                      su_valid;
   logic [rci_pkg::DISC_W-1:0] su_disc;
   rci_pkg::root_tag_type     su_tag;

   rci_setup u_setup (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid),
      .in_radius  (req_origin_radius),
      .in_z       (req_origin_z),
      .in_dir_z   (req_dir_z),
      .in_ray_cos (req_ray_cos),
      .cone_cos   (cone_cos_ff),
      .zero_tol   (zero_tol_ff),
      .out_valid  (su_valid),
      .out_disc   (su_disc),
      .out_tag    (su_tag)
   );

   // square root of the discriminant
   logic                       sq_valid;
   logic [rci_pkg::ROOT_W-1:0] sq_root;
   logic [ROOT_TAG_W-1:0]      sq_tag_vec;
   rci_pkg::root_tag_type      sq_tag;

   rci_sqrt #(
      .RAD_W (rci_pkg::DISC_W),
      .TAG_W (ROOT_TAG_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (su_valid),
      .in_rad    (su_disc),
      .in_tag    (su_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag_vec)
   );

   assign sq_tag = rci_pkg::root_tag_type'(sq_tag_vec);

   // q magnitude
   logic                  q_vld_ff;
   logic [63:0]           q_mag_ff;
   rci_pkg::root_tag_type q_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (enable) begin
         q_vld_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_mag_ff <= 64'(sq_tag.bmag) + sq_root;
         q_tag_ff <= sq_tag;
      end
   end

   // root candidates and divider operands
   logic                  qneg, q_nz, cand_a, cand_b;
   logic [63:0]           den_b;
   logic [93:0]           num_b;
   rci_pkg::hit_tag_type  div_tag_in;

   always_comb begin
      qneg   = !q_tag_ff.bneg && (q_tag_ff.bmag != '0);
      q_nz   = q_mag_ff != '0;
      cand_a = !q_tag_ff.linear && q_tag_ff.disc_ok && q_nz && (q_tag_ff.aneg == qneg);
      if (q_tag_ff.linear) begin
         cand_b = q_tag_ff.live_lin;
         den_b  = {q_tag_ff.bmag, 1'b0};
      end else begin
         cand_b = q_tag_ff.disc_ok && q_nz && (q_tag_ff.cmag != '0)
                  && (q_tag_ff.cneg == qneg);
         den_b  = q_mag_ff;
      end
      num_b             = {q_tag_ff.cmag, {rci_pkg::FRAC_W{1'b0}}};
      div_tag_in.cand_a = cand_a;
      div_tag_in.z      = q_tag_ff.z;
      div_tag_in.dz     = q_tag_ff.dz;
   end

   // first root q / a
   logic                        da_valid;
   logic [rci_pkg::DIST_W-1:0]  da_quo;
   logic [HIT_TAG_W-1:0]        da_tag_vec;
   rci_pkg::hit_tag_type        da_tag;

   rci_div #(
      .NUM_W (64),
      .DEN_W (rci_pkg::AMAG_W),
      .QUO_W (rci_pkg::CAP_EXP),
      .TAG_W (HIT_TAG_W)
   ) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (q_vld_ff),
      .in_num    (q_mag_ff),
      .in_den    (q_tag_ff.amag),
      .in_tag    (div_tag_in),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_tag   (da_tag_vec)
   );

   assign da_tag = rci_pkg::hit_tag_type'(da_tag_vec);

   // second root c / q, or the linear root
   logic                        db_valid;
   logic [rci_pkg::DIST_W-1:0]  db_quo;
   logic                        db_cand;

   rci_div #(
      .NUM_W (94),
      .DEN_W (64),
      .QUO_W (rci_pkg::CAP_EXP),
      .TAG_W (1)
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (q_vld_ff),
      .in_num    (num_b),
      .in_den    (den_b),
      .in_tag    (cand_b),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_tag   (db_cand)
   );

   // partial products of distance times |dz|
   logic [31:0]                 dz_abs;
   logic                        f1_vld_ff;
   logic [rci_pkg::DIST_W-1:0]  f1_da_ff, f1_db_ff;
   logic [62:0]                 f1_pa_lo_ff, f1_pb_lo_ff;
   logic [61:0]                 f1_pa_hi_ff, f1_pb_hi_ff;
   logic                        f1_cand_a_ff, f1_cand_b_ff, f1_dzneg_ff;
   logic signed [rci_pkg::LEN_W-1:0] f1_z_ff;

   assign dz_abs = da_tag.dz[31] ? 32'(-da_tag.dz) : 32'(da_tag.dz);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (enable) begin
         f1_vld_ff <= da_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         f1_da_ff     <= da_quo;
         f1_db_ff     <= db_quo;
         f1_pa_lo_ff  <= da_quo[31:0] * dz_abs[30:0];
         f1_pa_hi_ff  <= da_quo[62:32] * dz_abs[30:0];
         f1_pb_lo_ff  <= db_quo[31:0] * dz_abs[30:0];
         f1_pb_hi_ff  <= db_quo[62:32] * dz_abs[30:0];
         f1_cand_a_ff <= da_tag.cand_a;
         f1_cand_b_ff <= db_cand;
         f1_dzneg_ff  <= da_tag.dz[31];
         f1_z_ff      <= da_tag.z;
      end
   end

   // nappe test: sign of z + d*dz against the sign of the cone cosine
   function automatic logic on_nappe(input logic [62:0] lo, input logic [61:0] hi,
                                     input logic signed [31:0] z, input logic dzneg,
                                     input logic cc_pos, input logic cc_neg);
      logic [95:0] m;
      logic [95:0] zs;
      logic [95:0] v;
      logic        vzero;
      m     = (96'(hi) << 32) + 96'(lo);
      zs    = {{64{z[31]}}, z} << rci_pkg::FRAC_W;
      v     = dzneg ? zs - m : zs + m;
      vzero = v == '0;
      return (vzero && !cc_pos && !cc_neg) || (!vzero && !v[95] && cc_pos)
             || (v[95] && cc_neg);
   endfunction

   function automatic logic [31:0] sat_dist(input logic [rci_pkg::DIST_W-1:0] d);
      return (d[rci_pkg::DIST_W-1:32] != '0) ? '1 : d[31:0];
   endfunction

   logic        cc_pos, cc_neg, keep_a, keep_b;
   logic [31:0] sat_a, sat_b;

   always_comb begin
      cc_neg = cone_cos_ff[31];
      cc_pos = !cone_cos_ff[31] && (cone_cos_ff != '0);
      keep_a = f1_cand_a_ff && (f1_da_ff != '0)
               && on_nappe(f1_pa_lo_ff, f1_pa_hi_ff, f1_z_ff, f1_dzneg_ff, cc_pos, cc_neg);
      keep_b = f1_cand_b_ff && (f1_db_ff != '0)
               && on_nappe(f1_pb_lo_ff, f1_pb_hi_ff, f1_z_ff, f1_dzneg_ff, cc_pos, cc_neg);
      sat_a  = sat_dist(f1_da_ff);
      sat_b  = sat_dist(f1_db_ff);
   end

   // output register
   logic [rci_pkg::CNT_W-1:0] count_ff;
   logic [31:0]               first_ff, second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         count_ff  <= {1'b0, keep_a} + {1'b0, keep_b};
         first_ff  <= keep_a ? sat_a : (keep_b ? sat_b : '0);
         second_ff <= (keep_a && keep_b) ? sat_b : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit_count       = count_ff;
   assign rsp_first_distance  = first_ff;
   assign rsp_second_distance = second_ff;

   // checks
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      da_valid == db_valid)
      else $error("distance dividers out of step");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count != 2'd3)
      else $error("hit count beyond two");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_count != 2'd2) |-> rsp_second_distance == '0)
      else $error("second distance set without two hits");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit_count == 2'd0) |-> rsp_first_distance == '0)
      else $error("first distance set without a hit");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !f1_vld_ff) |=> !rsp_valid)
      else $error("result appeared from an empty stage");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam logic [rci_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rci_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam longint UNIT_Q30 = 64'sd1073741824;
   localparam logic [127:0] DIST_CAP = 128'h4000_0000_0000_0000;
   localparam int PIPE_DEPTH = 140;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [rci_pkg::CNT_W-1:0] count;
      logic [rci_pkg::LEN_W-1:0] first;
      logic [rci_pkg::LEN_W-1:0] second;
   } hits_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [rci_pkg::LEN_W-1:0] req_origin_radius = '0;
   logic signed [rci_pkg::LEN_W-1:0] req_origin_z = '0;
   logic signed [rci_pkg::COS_W-1:0] req_dir_z = '0;
   logic signed [rci_pkg::COS_W-1:0] req_ray_cos = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [rci_pkg::CNT_W-1:0] rsp_hit_count;
   logic [rci_pkg::LEN_W-1:0] rsp_first_distance;
   logic [rci_pkg::LEN_W-1:0] rsp_second_distance;
   logic csr_write = 1'b0;
   logic [rci_pkg::CSR_IDX_W-1:0] csr_index = rci_pkg::CSR_CONE_COS;
   logic [rci_pkg::COS_W-1:0] csr_data = '0;

   // local copy of the two registers
   logic signed [rci_pkg::COS_W-1:0] cone_cos_reg = rci_pkg::CONE_COS_RESET;
   logic [rci_pkg::TOL_W-1:0] zero_tol_reg = rci_pkg::ZERO_TOL_RESET;

   hits_type expected_hits[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   ray_cone_intersect DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // cosine limited to plus or minus one
   function automatic longint unit_clamp(input longint v);
      if (v > UNIT_Q30) return UNIT_Q30;
      if (v < -UNIT_Q30) return -UNIT_Q30;
      return v;
   endfunction

   function automatic logic [63:0] isqrt128(input logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // truncated quotient, held at the internal cap; zero divisor gives zero
   function automatic logic [63:0] div_cap(input logic [127:0] num, input logic [63:0] den);
      logic [127:0] q;
      if (den == 0) return '0;
      q = num / {64'd0, den};
      if (q >= DIST_CAP) return DIST_CAP[63:0];
      return q[63:0];
   endfunction

   // keep a root if positive and on the nappe of the cone cosine's sign
   function automatic void take_root(input logic [63:0] d, input longint z, input longint dz,
                                     input int cone_sign, inout hits_type h);
      logic signed [127:0] zs;
      logic signed [127:0] dzs;
      logic signed [127:0] zd;
      logic [rci_pkg::LEN_W-1:0] sat;
      int sg;
      if (d == 0 || h.count >= 2) return;
      zs = z;
      dzs = dz;
      zd = (zs <<< 30) + $signed({64'd0, d}) * dzs;
      sg = zd > 0 ? 1 : (zd < 0 ? -1 : 0);
      if (sg != cone_sign) return;
      sat = (d > 64'hFFFF_FFFF) ? '1 : d[31:0];
      if (h.count == 0) h.first = sat;
      else h.second = sat;
      h.count++;
   endfunction

   function automatic hits_type cone_hits(input logic [rci_pkg::LEN_W-1:0] r_in,
                                          input logic signed [rci_pkg::LEN_W-1:0] z_in,
                                          input logic signed [rci_pkg::COS_W-1:0] dz_in,
                                          input logic signed [rci_pkg::COS_W-1:0] rc_in);
      longint z, dz, rc, cc, a, b, t;
      logic [63:0] r, rcm, c2, d2, tmag, z2, u, cmag, bmag, amag, qmag;
      logic [127:0] w, b2, ac, disc;
      logic cneg, bneg, aneg, acneg, ok, qneg;
      int cone_sign;
      hits_type h;
      h = '{default: '0};
      r = {32'd0, r_in};
      z = z_in;
      dz = unit_clamp(longint'(dz_in));
      rc = unit_clamp(longint'(rc_in));
      cc = unit_clamp(longint'(cone_cos_reg));
      cone_sign = cc > 0 ? 1 : (cc < 0 ? -1 : 0);
      if (r == 0) return h;
      c2 = (cc * cc) >> 30;
      d2 = (dz * dz) >> 30;
      a = longint'(d2) - longint'(c2);
      rcm = rc < 0 ? -rc : rc;
      w = {64'd0, r} * {64'd0, rcm};
      w = w * {64'd0, c2};
      tmag = w[93:30];
      t = rc < 0 ? -longint'(tmag) : longint'(tmag);
      b = z * dz - t;
      z2 = z * z;
      w = {64'd0, r} * {64'd0, r};
      w = w * {64'd0, c2};
      u = w[93:30];
      cneg = z2 < u;
      cmag = cneg ? u - z2 : z2 - u;
      bneg = b < 0;
      aneg = a < 0;
      bmag = bneg ? -b : b;
      amag = aneg ? -a : a;
      if (amag <= {33'd0, zero_tol_reg}) begin
         // near-parallel ray: single linear root
         if (bmag != 0 && cmag != 0 && cneg != bneg)
            take_root(div_cap({34'd0, cmag, 30'd0}, bmag << 1), z, dz, cone_sign, h);
      end else begin
         b2 = {64'd0, bmag} * {64'd0, bmag};
         ac = ({64'd0, amag} * {64'd0, cmag}) << 30;
         acneg = cmag != 0 && aneg != cneg;
         ok = 1'b1;
         disc = b2;
         if (acneg) disc = b2 + ac;
         else if (b2 > ac) disc = b2 - ac;
         else ok = 1'b0;
         if (ok) begin
            qmag = bmag + isqrt128(disc);
            qneg = b > 0;
            if (qmag != 0 && aneg == qneg)
               take_root(div_cap({64'd0, qmag}, amag), z, dz, cone_sign, h);
            if (qmag != 0 && cmag != 0 && cneg == qneg)
               take_root(div_cap({34'd0, cmag, 30'd0}, qmag), z, dz, cone_sign, h);
         end
      end
      return h;
   endfunction

   // send one request and queue its prediction once accepted
   task automatic send_ray(input logic [rci_pkg::LEN_W-1:0] r,
                           input logic signed [rci_pkg::LEN_W-1:0] z,
                           input logic signed [rci_pkg::COS_W-1:0] dz,
                           input logic signed [rci_pkg::COS_W-1:0] rc);
      if (!quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_radius <= r;
      req_origin_z <= z;
      req_dir_z <= dz;
      req_ray_cos <= rc;
      do @(posedge clock); while (req_stall);
      expected_hits.push_back(cone_hits(r, z, dz, rc));
   endtask

   // wait until every queued result has come back
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_hits.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rci_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rci_pkg::COS_W-1:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == rci_pkg::CSR_CONE_COS) cone_cos_reg = data;
      else if (idx == rci_pkg::CSR_ZERO_TOL) zero_tol_reg = data[rci_pkg::TOL_W-1:0];
   endtask

   function automatic logic signed [rci_pkg::COS_W-1:0] rand_cos;
      return $signed($urandom_range(0, 2 * 32'd1073741824)) - rci_pkg::COS_ONE;
   endfunction

   // mostly moderate rays, some near the cone slope, some raw bit patterns
   task automatic send_random_ray;
      int mode;
      logic signed [rci_pkg::COS_W-1:0] dz;
      logic signed [rci_pkg::COS_W-1:0] cc;
      mode = $urandom_range(99);
      cc = rci_pkg::COS_W'(unit_clamp(longint'(cone_cos_reg)));
      if (mode < 10) begin
         send_ray($urandom, $urandom, $urandom, $urandom);
      end else if (mode < 20) begin
         dz = ($urandom_range(1) ? cc : -cc) + $signed($urandom_range(0, 8)) - 4;
         send_ray($urandom_range(1, 1 << 22), $signed($urandom_range(0, 1 << 23)) - (1 << 22),
                  dz, rand_cos());
      end else begin
         send_ray($urandom_range(1, 1 << 22), $signed($urandom_range(0, 1 << 23)) - (1 << 22),
                  rand_cos(), rand_cos());
      end
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin
      hits_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result: hit_count %0d", rsp_hit_count);
            errors++;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_hit_count !== e.count) begin
               $error("hit_count: expected %0d, got %0d", e.count, rsp_hit_count);
               errors++;
            end
            if (rsp_first_distance !== e.first) begin
               $error("first_distance: expected %0h, got %0h", e.first, rsp_first_distance);
               errors++;
            end
            if (rsp_second_distance !== e.second) begin
               $error("second_distance: expected %0h, got %0h", e.second,
                      rsp_second_distance);
               errors++;
            end
         end
      end
      rsp_stall <= !quiet && ($urandom_range(99) < 20);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic test_reset_values;
      repeat (5) send_random_ray();
   endtask

   task automatic test_special_cases;
      // zero origin radius
      send_ray('0, 32'sd4096, 32'sd500000000, 32'sd300000000);
      // field extremes and cosines beyond one
      send_ray('1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_ray(32'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_ray(32'd4096, 32'sd0, rci_pkg::COS_ONE, -rci_pkg::COS_ONE);
      send_ray(32'd4096, 32'sd0, -rci_pkg::COS_ONE, rci_pkg::COS_ONE);
      // ray along the cone slope: linear root
      send_ray(32'd8192, 32'sd4096, rci_pkg::CONE_COS_RESET, 32'sd0);
      send_ray(32'd8192, -32'sd4096, -rci_pkg::CONE_COS_RESET, 32'sd100000);
      // linear case with zero b
      send_ray(32'd8192, 32'sd0, rci_pkg::CONE_COS_RESET, 32'sd0);
      // zero b and no real root
      send_ray(32'd8192, 32'sd0, 32'sd0, 32'sd0);
      // pointing away from a far cone: no discriminant
      send_ray(32'd40960, 32'sd0, 32'sd0, rci_pkg::COS_ONE);
      // radial inward, crosses one nappe twice
      send_ray(32'd40960, 32'sd4096, 32'sd0, -rci_pkg::COS_ONE);
      // nearly parallel: huge distance saturates
      send_ray(32'hFFFF_0000, 32'sd4096, rci_pkg::CONE_COS_RESET + 32'sd3, 32'sd0);
      send_ray(32'd409600, -32'sd40960, rci_pkg::CONE_COS_RESET - 32'sd2, -32'sd1000);
      // tiny origin: sub-ulp roots
      send_ray(32'd1, 32'sd1, 32'sd600000000, -32'sd700000000);
      send_ray(32'd3, -32'sd2, -32'sd900000000, -32'sd200000000);
      // register index beyond the file is ignored
      write_reg(CSR_SPARE_2, 32'hDEAD_BEEF);
      write_reg(CSR_SPARE_3, 32'h1234_5678);
      send_ray(32'd40960, 32'sd4096, 32'sd0, -rci_pkg::COS_ONE);
   endtask

   task automatic test_register_sweep;
      logic [rci_pkg::COS_W-1:0] cos_set[8];
      logic [rci_pkg::COS_W-1:0] tol_set[8];
      cos_set = '{rci_pkg::CONE_COS_RESET, 32'd0, rci_pkg::COS_ONE, -rci_pkg::COS_ONE,
                  32'h7FFF_FFFF, 32'h8000_0000, -32'sd759250125, $urandom};
      tol_set = '{32'd1, 32'd0, 32'd1000, 32'h7FFF_FFFF, 32'd0, 32'd5, 32'd1 << 20, $urandom};
      for (int p = 0; p < 8; p++) begin
         write_reg(rci_pkg::CSR_CONE_COS, cos_set[p]);
         write_reg(rci_pkg::CSR_ZERO_TOL, tol_set[p]);
         // one phase runs without any idling
         quiet = (p == 2);
         for (int i = 0; i < 135; i++) begin
            send_random_ray();
            if (p == 4 && i == 60) drain();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_special_cases();
      test_register_sweep();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/rci_pkg.sv
rtl/rci_setup.sv
rtl/rci_sqrt.sv
rtl/rci_div.sv
rtl/ray_cone_intersect.sv
verif/tb_top.sv
